// ===== rtl/rtp_header_parser_macros.svh =====
// Assertion macros shared by the RTP header parser RTL.
`ifndef RTP_HEADER_PARSER_MACROS_SVH
`define RTP_HEADER_PARSER_MACROS_SVH

// Same-cycle implication, checked while out of reset.
`define RHP_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked while out of reset.
`define RHP_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/rtp_hp_pkg.sv =====
// Package for the RTP header parser: field widths, result codes and constants.
`timescale 1ns / 1ps

package rtp_hp_pkg;

    // Fixed header layout
    localparam int FIXED_HEADER_BYTES = 12;
    localparam logic [1:0] EXPECTED_VERSION = 2'd2;

    // Channel widths
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 128;
    localparam int M_TUSER_W = 2;

    // Result kinds (travel in tuser)
    localparam logic [1:0] KIND_HEADER  = 2'd0;
    localparam logic [1:0] KIND_CSRC    = 2'd1;
    localparam logic [1:0] KIND_PAYLOAD = 2'd2;
    localparam logic [1:0] KIND_STATUS  = 2'd3;

    // Status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_UNDERFLOW = 2'd1;
    localparam logic [1:0] ST_VERSION   = 2'd2;
    localparam logic [1:0] ST_TRUNCATED = 2'd3;

    // One result item before packing
    typedef struct packed {
        logic [31:0] data_word;
        logic [31:0] sync_source;
        logic [31:0] time_stamp;
        logic [15:0] sequence_number;
        logic [3:0]  csrc_count;
        logic        extension_flag;
        logic        padding_flag;
        logic [6:0]  payload_type;
        logic        marker;
        logic [1:0]  status;
    } result_t;

endpackage

// ===== rtl/rtp_header_parser.sv =====
// RTP fixed header parser: byte stream in, header / CSRC / payload results out.
//
//  channel | dir | tdata                     | tuser | tlast
//  s_      | in  | data_byte                 | -     | packet_end
//  m_      | out | status .. data_word (128) | kind  | final_result
//
// One byte is taken per cycle while m_ does not stall; the byte is held in
// the input register, then its result, if any, in the result register.
// Throughput is one byte per cycle unless m_ stalls, set by the parse logic
// between the two registers; bytes with no result also wait for a free slot.
// aresetn is synchronous and active low; it returns the parser to the
// start of a packet. A stall on m_ holds the result and back-pressures s_.
`timescale 1ns / 1ps
`include "rtp_header_parser_macros.svh"

module rtp_header_parser (
    input  logic                              aclk,
    input  logic                              aresetn,
    // s_tdata: data_byte[7:0]
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [rtp_hp_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic                              s_tlast,
    // m_tdata: status[1:0], marker[2], payload_type[9:3], padding_flag[10],
    //          extension_flag[11], csrc_count[15:12], sequence_number[31:16],
    //          time_stamp[63:32], sync_source[95:64], data_word[127:96]
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [rtp_hp_pkg::M_TDATA_W-1:0]  m_tdata,
    // m_tuser: kind[1:0]
    output logic [rtp_hp_pkg::M_TUSER_W-1:0]  m_tuser,
    output logic                              m_tlast
);

    import rtp_hp_pkg::*;

    localparam int POS_W = $clog2(FIXED_HEADER_BYTES);
    localparam logic [POS_W-1:0] POS_LAST  = POS_W'(FIXED_HEADER_BYTES - 1);
    localparam logic [POS_W-1:0] POS_WORD  = POS_W'(4);
    localparam logic [POS_W-1:0] POS_CSRC3 = POS_W'(3);

    // Parser phase codes
    localparam logic [1:0] PH_FIXED   = 2'd0;
    localparam logic [1:0] PH_CSRC    = 2'd1;
    localparam logic [1:0] PH_PAYLOAD = 2'd2;
    localparam logic [1:0] PH_DISCARD = 2'd3;

    // Input register
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;

    // Parser state
    logic [1:0]       phase_reg, phase_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [63:0]      hdr_shift_reg, hdr_shift_next;
    logic [31:0]      word_shift_reg, word_shift_next;
    logic [3:0]       csrc_left_reg, csrc_left_next;
    logic             bad_ver_reg, bad_ver_next;

    // Result register
    logic                 out_valid_reg;
    logic [M_TDATA_W-1:0] out_data_reg;
    logic [1:0]           out_kind_reg;
    logic                 out_last_reg;

    logic    advance;
    logic    fire;
    logic    res_valid;
    logic    res_last;
    logic [1:0] res_kind;
    result_t res;
    logic [31:0] word_cat;
    logic [3:0]  csrc_dec;

    // The result slot frees when empty or taken this cycle
    assign advance  = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    assign word_cat = {word_shift_reg[23:0], in_byte_reg};
    assign csrc_dec = csrc_left_reg - 4'd1;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata[7:0];
            in_last_reg <= s_tlast;
        end
    end

    // Parse one byte
    always_comb begin
        phase_next      = phase_reg;
        pos_next        = pos_reg;
        hdr_shift_next  = hdr_shift_reg;
        word_shift_next = word_shift_reg;
        csrc_left_next  = csrc_left_reg;
        bad_ver_next    = bad_ver_reg;
        res_valid       = 1'b0;
        res_last        = 1'b0;
        res_kind        = KIND_HEADER;
        res             = '0;

        unique case (phase_reg)
            PH_FIXED: begin
                if (pos_reg < POS_WORD) begin
                    word_shift_next = word_cat;
                end else begin
                    hdr_shift_next = {hdr_shift_reg[55:0], in_byte_reg};
                end
                if (pos_reg == '0) begin
                    bad_ver_next = (in_byte_reg[7:6] != EXPECTED_VERSION);
                end
                if (pos_reg < POS_LAST) begin
                    if (in_last_reg) begin
                        // packet shorter than the fixed header
                        res_valid  = 1'b1;
                        res_kind   = KIND_STATUS;
                        res.status = ST_UNDERFLOW;
                        res_last   = 1'b1;
                    end else begin
                        pos_next = pos_reg + 1'b1;
                    end
                end else if (bad_ver_reg) begin
                    res_valid  = 1'b1;
                    res_kind   = KIND_STATUS;
                    res.status = ST_VERSION;
                    res_last   = 1'b1;
                end else begin
                    // header result from the collected bytes
                    res_valid           = 1'b1;
                    res_kind            = KIND_HEADER;
                    res.marker          = word_shift_reg[23];
                    res.payload_type    = word_shift_reg[22:16];
                    res.padding_flag    = word_shift_reg[29];
                    res.extension_flag  = word_shift_reg[28];
                    res.csrc_count      = word_shift_reg[27:24];
                    res.sequence_number = word_shift_reg[15:0];
                    res.time_stamp      = hdr_shift_next[63:32];
                    res.sync_source     = hdr_shift_next[31:0];
                    res_last            = in_last_reg;
                    if (word_shift_reg[27:24] != 4'd0 && in_last_reg) begin
                        res.status = ST_TRUNCATED;
                    end
                end
            end
            PH_CSRC: begin
                word_shift_next = word_cat;
                if (pos_reg < POS_CSRC3) begin
                    if (in_last_reg) begin
                        // partial CSRC word is dropped
                        res_valid  = 1'b1;
                        res_kind   = KIND_STATUS;
                        res.status = ST_TRUNCATED;
                        res_last   = 1'b1;
                    end else begin
                        pos_next = pos_reg + 1'b1;
                    end
                end else begin
                    res_valid      = 1'b1;
                    res_kind       = KIND_CSRC;
                    res.data_word  = word_cat;
                    res_last       = in_last_reg;
                    csrc_left_next = csrc_dec;
                    pos_next       = '0;
                    word_shift_next = '0;
                    if (csrc_dec == 4'd0) begin
                        phase_next = PH_PAYLOAD;
                    end else if (in_last_reg) begin
                        res.status = ST_TRUNCATED;
                    end
                end
            end
            PH_PAYLOAD: begin
                res_valid     = 1'b1;
                res_kind      = KIND_PAYLOAD;
                res.data_word = {24'd0, in_byte_reg};
                res_last      = in_last_reg;
            end
            PH_DISCARD: begin
                res_last = in_last_reg;
            end
            default: begin
                phase_next = PH_FIXED;
            end
        endcase

        // Leaving the fixed header without an error
        if (phase_reg == PH_FIXED && pos_reg == POS_LAST && !bad_ver_reg && !in_last_reg) begin
            pos_next = '0;
            if (word_shift_reg[27:24] == 4'd0) begin
                phase_next = PH_PAYLOAD;
            end else begin
                phase_next      = PH_CSRC;
                csrc_left_next  = word_shift_reg[27:24];
                word_shift_next = '0;
            end
        end

        // End of packet: back to a clean start
        if (res_last) begin
            phase_next      = PH_FIXED;
            pos_next        = '0;
            hdr_shift_next  = '0;
            word_shift_next = '0;
            csrc_left_next  = '0;
            bad_ver_next    = 1'b0;
        end

        // Wrong version mid-packet: swallow the rest
        if (phase_reg == PH_FIXED && pos_reg == POS_LAST && bad_ver_reg && !in_last_reg) begin
            phase_next      = PH_DISCARD;
            pos_next        = '0;
            hdr_shift_next  = '0;
            word_shift_next = '0;
            csrc_left_next  = '0;
            bad_ver_next    = 1'b0;
        end
    end

    // Parser state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_FIXED;
            pos_reg        <= '0;
            hdr_shift_reg  <= '0;
            word_shift_reg <= '0;
            csrc_left_reg  <= '0;
            bad_ver_reg    <= 1'b0;
        end else if (fire) begin
            phase_reg      <= phase_next;
            pos_reg        <= pos_next;
            hdr_shift_reg  <= hdr_shift_next;
            word_shift_reg <= word_shift_next;
            csrc_left_reg  <= csrc_left_next;
            bad_ver_reg    <= bad_ver_next;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= fire && res_valid;
        end
        if (fire && res_valid) begin
            out_data_reg <= res;
            out_kind_reg <= res_kind;
            out_last_reg <= res_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

    // Checks on the parser's own state
    `RHP_ASSERT_NOW(a_csrc_left, aclk, aresetn, phase_reg == PH_CSRC, csrc_left_reg != 4'd0,
        "CSRC phase with no words left")
    `RHP_ASSERT_NOW(a_csrc_pos, aclk, aresetn, phase_reg == PH_CSRC, pos_reg <= POS_CSRC3,
        "CSRC byte position out of range")
    `RHP_ASSERT_NOW(a_fixed_pos, aclk, aresetn, phase_reg == PH_FIXED, pos_reg <= POS_LAST,
        "fixed header byte position out of range")
    `RHP_ASSERT_NOW(a_status_final, aclk, aresetn, m_tvalid && m_tuser == KIND_STATUS, m_tlast,
        "status-only result not marked final")
    `RHP_ASSERT_NEXT(a_in_hold, aclk, aresetn, in_valid_reg && !advance, in_valid_reg,
        "buffered byte lost during output stall")

endmodule

// ===== tb/tb_rtp_header_parser.sv =====
// Self-checking testbench for the RTP fixed header parser, byte stream in, results out.
`timescale 1ns / 1ps

module tb_rtp_header_parser;

    import rtp_hp_pkg::*;

    localparam int RAND_BYTES  = 1400;
    localparam int DIR_ROWS    = 25;
    localparam int DRAIN_LIMIT = 20000;
    localparam int MAX_REPORTS = 10;

    // Parser phases, tracked by the predictor
    typedef enum logic [2:0] {
        PH_HDR,
        PH_CSRC,
        PH_PAYLOAD,
        PH_DISCARD
    } parse_phase_t;

    // One expected result: kind (tuser), last flag (tlast) and the tdata fields
    typedef struct packed {
        logic [1:0] kind;
        logic       last;
        result_t    res;
    } rtp_item_t;

    // One directed stimulus row; typed rows carry the result read off by hand
    typedef struct packed {
        logic [7:0] b;
        logic       eop;
        logic       typed;
        logic [1:0] kind;
        logic [1:0] status;
    } dir_row_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 s_tlast  = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;
    logic                 m_tlast;

    // Side-band travelling with each byte: hand-typed expectation, if any
    logic       row_typed  = 1'b0;
    logic [1:0] row_kind   = KIND_HEADER;
    logic [1:0] row_status = ST_OK;

    // Predictor state
    logic [6:0]   ps_pos;
    parse_phase_t ps_phase;
    logic [63:0]  ps_hdr;
    logic [31:0]  ps_word;
    logic [3:0]   ps_left;
    logic         ps_badver;

    rtp_item_t want_q[$];
    rtp_item_t want_item;
    rtp_item_t got_item;
    string     bad_fields;
    bit        have_result;

    int mismatches = 0;
    int sent       = 0;
    int packets    = 0;
    int n_kind [4] = '{0, 0, 0, 0};
    int burst_left = 0;

    // Receiver pattern state
    int rx_mode  = 0;
    int rx_left  = 0;
    int rx_cycle = 0;

    // Directed part: short packet, wrong version at all zeros, 0xbf then all-ones
    // header ending on byte 12 with CSRC words still due
    dir_row_t dir_tab [0:DIR_ROWS-1] = '{
        '{8'hff, 1'b1, 1'b1, KIND_STATUS, ST_UNDERFLOW},
        '{8'h00, 1'b0, 1'b0, KIND_HEADER, ST_OK},
        '{8'h00, 1'b0, 1'b0, KIND_HEADER, ST_OK},
        '{8'h00, 1'b0, 1'b0, KIND_HEADER, ST_OK},
        '{8'h00, 1'b0, 1'b0, KIND_HEADER, ST_OK},
        '{8'h00, 1'b0, 1'b0, KIND_HEADER, ST_OK},
        '{8'h00, 1'b0, 1'b0, KIND_HEADER, ST_OK},
        '{8'h00, 1'b0, 1'b0, KIND_HEADER, ST_OK},
        '{8'h00, 1'b0, 1'b0, KIND_HEADER, ST_OK},
        '{8'h00, 1'b0, 1'b0, KIND_HEADER, ST_OK},
        '{8'h00, 1'b0, 1'b0, KIND_HEADER, ST_OK},
        '{8'h00, 1'b0, 1'b0, KIND_HEADER, ST_OK},
        '{8'h00, 1'b1, 1'b1, KIND_STATUS, ST_VERSION},
        '{8'hbf, 1'b0, 1'b0, KIND_HEADER, ST_OK},
        '{8'hff, 1'b0, 1'b0, KIND_HEADER, ST_OK},
        '{8'hff, 1'b0, 1'b0, KIND_HEADER, ST_OK},
        '{8'hff, 1'b0, 1'b0, KIND_HEADER, ST_OK},
        '{8'hff, 1'b0, 1'b0, KIND_HEADER, ST_OK},
        '{8'hff, 1'b0, 1'b0, KIND_HEADER, ST_OK},
        '{8'hff, 1'b0, 1'b0, KIND_HEADER, ST_OK},
        '{8'hff, 1'b0, 1'b0, KIND_HEADER, ST_OK},
        '{8'hff, 1'b0, 1'b0, KIND_HEADER, ST_OK},
        '{8'hff, 1'b0, 1'b0, KIND_HEADER, ST_OK},
        '{8'hff, 1'b0, 1'b0, KIND_HEADER, ST_OK},
        '{8'hff, 1'b1, 1'b0, KIND_HEADER, ST_OK}
    };

    rtp_header_parser i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #5 aclk = ~aclk;

    // Run limit, well above the slowest legal run
    initial begin
        #5000000;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic void rtp_restart();
        ps_pos    = '0;
        ps_phase  = PH_HDR;
        ps_hdr    = '0;
        ps_word   = '0;
        ps_left   = '0;
        ps_badver = 1'b0;
    endfunction

    function automatic rtp_item_t status_item(input logic [1:0] code);
        rtp_item_t r;
        r            = '0;
        r.kind       = KIND_STATUS;
        r.res.status = code;
        r.last       = 1'b1;
        return r;
    endfunction

    // Next-state and result for one accepted packet byte
    function automatic bit rtp_predict(input logic [7:0] b, input logic eop,
                                       output rtp_item_t r);
        logic [3:0] cc;
        logic [6:0] pos1;
        r = '0;
        unique case (ps_phase)
            PH_HDR: begin
                if (ps_pos < 7'd4)
                    ps_word = {ps_word[23:0], b};
                else
                    ps_hdr = {ps_hdr[55:0], b};
                if (ps_pos == 7'd0)
                    ps_badver = (b[7:6] != EXPECTED_VERSION);
                if (ps_pos < 7'(FIXED_HEADER_BYTES - 1)) begin
                    if (eop) begin
                        r = status_item(ST_UNDERFLOW);
                        rtp_restart();
                        return 1'b1;
                    end
                    ps_pos = ps_pos + 7'd1;
                    return 1'b0;
                end
                if (ps_badver) begin
                    r = status_item(ST_VERSION);
                    rtp_restart();
                    if (!eop)
                        ps_phase = PH_DISCARD;
                    return 1'b1;
                end
                cc                   = ps_word[27:24];
                r.kind               = KIND_HEADER;
                r.res.marker         = ps_word[23];
                r.res.payload_type   = ps_word[22:16];
                r.res.padding_flag   = ps_word[29];
                r.res.extension_flag = ps_word[28];
                r.res.csrc_count     = cc;
                r.res.sequence_number = ps_word[15:0];
                r.res.time_stamp     = ps_hdr[63:32];
                r.res.sync_source    = ps_hdr[31:0];
                if (cc == 4'd0) begin
                    r.last = eop;
                    if (eop) begin
                        rtp_restart();
                    end else begin
                        ps_phase = PH_PAYLOAD;
                        ps_pos   = '0;
                    end
                end else if (eop) begin
                    // header done but CSRC words still owed
                    r.res.status = ST_TRUNCATED;
                    r.last       = 1'b1;
                    rtp_restart();
                end else begin
                    ps_left  = cc;
                    ps_phase = PH_CSRC;
                    ps_pos   = '0;
                    ps_word  = '0;
                end
                return 1'b1;
            end
            PH_CSRC: begin
                pos1    = ps_pos + 7'd1;
                ps_word = {ps_word[23:0], b};
                if (pos1 < 7'd4) begin
                    if (eop) begin
                        // partial word is dropped
                        r = status_item(ST_TRUNCATED);
                        rtp_restart();
                        return 1'b1;
                    end
                    ps_pos = pos1;
                    return 1'b0;
                end
                ps_left         = ps_left - 4'd1;
                r.kind          = KIND_CSRC;
                r.res.data_word = ps_word;
                if (ps_left == 4'd0) begin
                    r.last = eop;
                    if (eop) begin
                        rtp_restart();
                    end else begin
                        ps_phase = PH_PAYLOAD;
                        ps_pos   = '0;
                        ps_word  = '0;
                    end
                end else if (eop) begin
                    r.res.status = ST_TRUNCATED;
                    r.last       = 1'b1;
                    rtp_restart();
                end else begin
                    ps_pos  = '0;
                    ps_word = '0;
                end
                return 1'b1;
            end
            PH_PAYLOAD: begin
                r.kind          = KIND_PAYLOAD;
                r.res.data_word = {24'd0, b};
                r.last          = eop;
                if (eop)
                    rtp_restart();
                return 1'b1;
            end
            default: begin
                if (eop)
                    rtp_restart();
                return 1'b0;
            end
        endcase
    endfunction

    task automatic note_mismatch(input string what);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("MISMATCH @%0t: %s", $time, what);
    endtask

    // Result check first, then prediction for the byte taken at this edge
    always @(posedge aclk) begin
        if (!aresetn) begin
            rtp_restart();
        end else begin
            if (m_tvalid && m_tready) begin
                got_item.kind = m_tuser;
                got_item.last = m_tlast;
                got_item.res  = result_t'(m_tdata);
                n_kind[m_tuser]++;
                if (want_q.size() == 0) begin
                    note_mismatch($sformatf("unexpected result kind=%0d last=%0d tdata=%h",
                                            got_item.kind, got_item.last, m_tdata));
                end else begin
                    want_item  = want_q.pop_front();
                    bad_fields = "";
                    if (got_item.kind != want_item.kind) bad_fields = {bad_fields, " kind"};
                    if (got_item.last != want_item.last) bad_fields = {bad_fields, " last"};
                    if (got_item.res.status != want_item.res.status)
                        bad_fields = {bad_fields, " status"};
                    if (got_item.res.marker != want_item.res.marker)
                        bad_fields = {bad_fields, " marker"};
                    if (got_item.res.payload_type != want_item.res.payload_type)
                        bad_fields = {bad_fields, " payload_type"};
                    if (got_item.res.padding_flag != want_item.res.padding_flag)
                        bad_fields = {bad_fields, " padding_flag"};
                    if (got_item.res.extension_flag != want_item.res.extension_flag)
                        bad_fields = {bad_fields, " extension_flag"};
                    if (got_item.res.csrc_count != want_item.res.csrc_count)
                        bad_fields = {bad_fields, " csrc_count"};
                    if (got_item.res.sequence_number != want_item.res.sequence_number)
                        bad_fields = {bad_fields, " sequence_number"};
                    if (got_item.res.time_stamp != want_item.res.time_stamp)
                        bad_fields = {bad_fields, " time_stamp"};
                    if (got_item.res.sync_source != want_item.res.sync_source)
                        bad_fields = {bad_fields, " sync_source"};
                    if (got_item.res.data_word != want_item.res.data_word)
                        bad_fields = {bad_fields, " data_word"};
                    if (bad_fields != "")
                        note_mismatch($sformatf(
                            "%s | exp kind=%0d last=%0d %h | got kind=%0d last=%0d %h",
                            bad_fields, want_item.kind, want_item.last, want_item.res,
                            got_item.kind, got_item.last, got_item.res));
                end
            end
            if (s_tvalid && s_tready) begin
                have_result = rtp_predict(s_tdata, s_tlast, want_item);
                if (row_typed) begin
                    want_item      = status_item(row_status);
                    want_item.kind = row_kind;
                    have_result    = 1'b1;
                end
                if (have_result)
                    want_q.push_back(want_item);
            end
        end
    end

    // Receiver: ready pattern switches between four modes when rx_left runs out
    always @(posedge aclk) begin
        rx_cycle <= rx_cycle + 1;
        if (rx_left == 0) begin
            rx_mode <= $urandom_range(0, 3);
            rx_left <= $urandom_range(50, 300);
        end else begin
            rx_left <= rx_left - 1;
        end
        unique case (rx_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= 1'($urandom_range(0, 1));
            2: m_tready <= ((rx_cycle % 8) < 5);
            default: begin
                // long runs of stall and ready
                if ($urandom_range(0, 15) == 0)
                    m_tready <= ~m_tready;
            end
        endcase
    end

    // One byte transfer, with burst/gap idling in front of it
    task automatic send_byte(input logic [7:0] b, input logic eop, input logic typed,
                             input logic [1:0] kind, input logic [1:0] status);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid   <= 1'b1;
        s_tdata    <= b;
        s_tlast    <= eop;
        row_typed  <= typed;
        row_kind   <= kind;
        row_status <= status;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sent++;
        if (eop)
            packets++;
    endtask

    // Hold the sender until every expected result is out, then let the pipe settle
    task automatic drain_results();
        int n;
        s_tvalid <= 1'b0;
        n = 0;
        while (want_q.size() != 0 && n < DRAIN_LIMIT) begin
            @(posedge aclk);
            n++;
        end
        repeat (6) @(posedge aclk);
    endtask

    initial begin : stim
        int         pick;
        int         cc;
        int         plen;
        int         total;
        bit         noise;
        bit         paused;
        logic [1:0] ver;
        logic [7:0] b;
        logic       eop;

        paused = 1'b0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed table
        for (int r = 0; r < DIR_ROWS; r++)
            send_byte(dir_tab[r].b, dir_tab[r].eop, dir_tab[r].typed,
                      dir_tab[r].kind, dir_tab[r].status);
        drain_results();

        // Random packets: mostly well formed, the rest cut short or broken
        while (sent < RAND_BYTES + DIR_ROWS) begin
            if (!paused && sent > (RAND_BYTES / 2)) begin
                drain_results();
                paused = 1'b1;
            end
            pick  = $urandom_range(0, 99);
            cc    = $urandom_range(0, 15);
            ver   = EXPECTED_VERSION;
            noise = 1'b0;
            if (pick < 60) begin
                if ($urandom_range(0, 3) != 0)
                    cc = $urandom_range(0, 2);
                plen  = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 16);
                total = FIXED_HEADER_BYTES + 4 * cc + plen;
            end else if (pick < 70) begin
                // short packet, any first byte
                ver   = 2'($urandom_range(0, 3));
                total = $urandom_range(1, FIXED_HEADER_BYTES - 1);
            end else if (pick < 80) begin
                // ends inside the CSRC list
                if (cc == 0)
                    cc = 1;
                total = FIXED_HEADER_BYTES + $urandom_range(1, 4 * cc - 1);
            end else if (pick < 85) begin
                // ends on the last header byte with CSRC words due
                if (cc == 0)
                    cc = 1;
                total = FIXED_HEADER_BYTES;
            end else if (pick < 95) begin
                ver = 2'($urandom_range(0, 2));
                if (ver == EXPECTED_VERSION)
                    ver = 2'd3;
                total = $urandom_range(FIXED_HEADER_BYTES, 24);
            end else begin
                noise = 1'b1;
                total = $urandom_range(1, 20);
            end
            for (int i = 0; i < total; i++) begin
                b = 8'($urandom_range(0, 255));
                if (i == 0 && !noise) begin
                    b[7:6] = ver;
                    b[3:0] = cc[3:0];
                end
                eop = (i == total - 1) || (noise && $urandom_range(0, 7) == 0);
                send_byte(b, eop, 1'b0, KIND_HEADER, ST_OK);
            end
        end

        drain_results();
        repeat (10) @(posedge aclk);
        if (want_q.size() != 0)
            note_mismatch($sformatf("%0d expected results never arrived", want_q.size()));

        $display("Covered %0d bytes in %0d packets; %0d mismatches.", sent, packets, mismatches);
        $display("Results: %0d headers, %0d CSRC words, %0d payload bytes, %0d status only.",
                 n_kind[KIND_HEADER], n_kind[KIND_CSRC], n_kind[KIND_PAYLOAD],
                 n_kind[KIND_STATUS]);
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
